/* design/hmvt_pkg.sv */
package hmvt_pkg;

	// Fixed field widths
	localparam int OPCODE_W = 2;
	localparam int BIN_W    = 8;
	localparam int ADD_W    = 32;
	localparam int THR_W    = 8;

	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_THRESH = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_SPARE  = 2'd3;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR,
		S_SUM_RD,
		S_SUM_MUL,
		S_SUM_ACC,
		S_SUM_CHK,
		S_SCAN_RD,
		S_SCAN_MUL,
		S_SCAN_ACC,
		S_SCAN_CHK,
		S_MUL_GO,
		S_MUL_WAIT,
		S_CMP,
		S_NEXT,
		S_RES
	} state_t;

	// Products of one split, in the order they are formed
	typedef enum logic [2:0] {
		M_P,
		M_Q,
		M_NUM,
		M_DEN,
		M_X,
		M_Y
	} mul_sel_t;

	typedef enum logic [1:0] {
		RA_BIN,
		RA_T,
		RA_TM1
	} ra_sel_t;

	typedef struct packed {
		logic     cap;
		logic     t_zero;
		logic     t_one;
		logic     t_inc;
		logic     clr_we;
		logic     add_we;
		ra_sel_t  ra_sel;
		logic     prod_ld;
		logic     sum_acc;
		logic     scan_init;
		logic     scan_acc;
		logic     mul_go;
		logic     mul_store;
		mul_sel_t mul_sel;
		logic     cmp;
		logic     res_load;
	} cmd_t;

	typedef struct packed {
		logic bin_ok;
		logic t_last;
		logic all_zero;
		logic side_zero;
		logic mul_busy;
		logic res_free;
	} sts_t;

endpackage

/* design/hmvt_mul.sv */
module hmvt_mul #(
	parameter int AW = 176,
	parameter int BW = 88
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             busy,
	output logic [AW+BW-1:0] prod
);
	localparam int PW = AW + BW;

	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [PW-1:0] acc_q;
	logic          busy_q;

	// Shift-add, one multiplier bit per cycle; stop once the multiplier runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

/* design/hmvt_dp.sv */
module hmvt_dp #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [hmvt_pkg::BIN_W-1:0]   bin_index,
	input  logic [hmvt_pkg::ADD_W-1:0]   add_count,
	input  hmvt_pkg::cmd_t               cmd,
	output hmvt_pkg::sts_t               sts,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hmvt_pkg::THR_W-1:0]   threshold_bin,
	output logic                         histogram_empty
);
	import hmvt_pkg::*;

	localparam int IDX_W = $clog2(BINS);
	localparam int NW    = COUNT_BITS + IDX_W;
	localparam int SW    = COUNT_BITS + 2 * IDX_W;
	localparam int BW    = NW + SW;
	localparam int AW    = 2 * BW;
	localparam int DW    = 2 * NW;
	localparam int PW    = AW + BW;
	localparam int PRW   = COUNT_BITS + IDX_W;
	localparam int SUMW  = ((COUNT_BITS > ADD_W) ? COUNT_BITS : ADD_W) + 1;

	logic [COUNT_BITS-1:0] mem [BINS];

	logic [IDX_W-1:0]      t_q, bin_q, raddr, ridx_q, waddr, ans_q;
	logic [ADD_W-1:0]      add_q;
	logic [COUNT_BITS-1:0] rdata_q, cnt_q, wdata, sat_cnt;
	logic [SUMW-1:0]       sat_sum;
	logic [PRW-1:0]        prod_q;
	logic [NW-1:0]         nall_q, nb_q, nf;
	logic [SW-1:0]         sall_q, sb_q, sf;
	logic [PW-1:0]         p_q, q_q, mul_p;
	logic [BW-1:0]         d, mul_b;
	logic [AW-1:0]         num_q, bnum_q, mul_a;
	logic [DW-1:0]         den_q, bden_q;
	logic                  mul_busy;
	logic                  out_valid_q, empty_q;
	logic [THR_W-1:0]      thr_q;

	// Bin memory: one write port, one registered read port
	always_comb begin
		unique case (cmd.ra_sel)
			RA_BIN:  raddr = bin_q;
			RA_T:    raddr = t_q;
			RA_TM1:  raddr = t_q - 1'b1;
			default: raddr = t_q;
		endcase
	end

	assign sat_sum = SUMW'(rdata_q) + SUMW'(add_q);
	assign sat_cnt = (sat_sum > SUMW'({COUNT_BITS{1'b1}})) ? '1 : COUNT_BITS'(sat_sum);
	assign waddr   = cmd.clr_we ? t_q : bin_q;
	assign wdata   = cmd.clr_we ? '0 : sat_cnt;

	always_ff @(posedge clk) begin
		if (cmd.clr_we || cmd.add_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		ridx_q  <= raddr;
	end

	// Bin counter for clearing, summing and scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
		end else if (cmd.t_zero) begin
			t_q <= '0;
		end else if (cmd.t_one) begin
			t_q <= IDX_W'(1);
		end else if (cmd.t_inc) begin
			t_q <= t_q + 1'b1;
		end
	end

	assign nf = nall_q - nb_q;
	assign sf = sall_q - sb_q;
	assign d  = (p_q >= q_q) ? BW'(p_q - q_q) : BW'(q_q - p_q);

	always_comb begin
		unique case (cmd.mul_sel)
			M_P: begin
				mul_a = AW'(sb_q);
				mul_b = BW'(nf);
			end
			M_Q: begin
				mul_a = AW'(sf);
				mul_b = BW'(nb_q);
			end
			M_NUM: begin
				mul_a = AW'(d);
				mul_b = d;
			end
			M_DEN: begin
				mul_a = AW'(nb_q);
				mul_b = BW'(nf);
			end
			M_X: begin
				mul_a = num_q;
				mul_b = BW'(bden_q);
			end
			M_Y: begin
				mul_a = bnum_q;
				mul_b = BW'(den_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	hmvt_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_go),
		.a     (mul_a),
		.b     (mul_b),
		.busy  (mul_busy),
		.prod  (mul_p)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			bin_q  <= IDX_W'(bin_index);
			add_q  <= add_count;
			nall_q <= '0;
			sall_q <= '0;
		end
		if (cmd.prod_ld) begin
			prod_q <= ridx_q * rdata_q;
			cnt_q  <= rdata_q;
		end
		if (cmd.sum_acc) begin
			nall_q <= nall_q + NW'(cnt_q);
			sall_q <= sall_q + SW'(prod_q);
		end
		if (cmd.scan_init) begin
			nb_q   <= '0;
			sb_q   <= '0;
			bnum_q <= '0;
			bden_q <= DW'(1);
			ans_q  <= '0;
		end
		if (cmd.scan_acc) begin
			nb_q <= nb_q + NW'(cnt_q);
			sb_q <= sb_q + SW'(prod_q);
		end
		if (cmd.mul_store) begin
			case (cmd.mul_sel)
				M_P, M_X: p_q   <= mul_p;
				M_Q, M_Y: q_q   <= mul_p;
				M_NUM:    num_q <= AW'(mul_p);
				M_DEN:    den_q <= DW'(mul_p);
				default:  ;
			endcase
		end
		// Keep the first maximum: replace only on strictly greater
		if (cmd.cmp && (p_q > q_q)) begin
			bnum_q <= num_q;
			bden_q <= den_q;
			ans_q  <= t_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			thr_q   <= THR_W'(ans_q);
			empty_q <= (nall_q == '0);
		end
	end

	assign sts.bin_ok    = (int'(bin_index) < BINS);
	assign sts.t_last    = (t_q == IDX_W'(BINS - 1));
	assign sts.all_zero  = (nall_q == '0);
	assign sts.side_zero = (nb_q == '0) || (nf == '0);
	assign sts.mul_busy  = mul_busy;
	assign sts.res_free  = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign threshold_bin   = thr_q;
	assign histogram_empty = empty_q;

endmodule

/* design/hmvt_ctrl.sv */
module hmvt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hmvt_pkg::OPCODE_W-1:0] opcode,
	input  hmvt_pkg::sts_t                sts,
	output hmvt_pkg::cmd_t                cmd
);
	import hmvt_pkg::*;

	state_t   state_q, state_d;
	mul_sel_t sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sel_q   <= M_P;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		unique case (state_q)
			S_CLEAR:    if (sts.t_last) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					unique case (opcode)
						OP_CLEAR:  state_d = S_CLEAR;
						OP_ADD:    state_d = sts.bin_ok ? S_ADD_RD : S_IDLE;
						OP_THRESH: state_d = S_SUM_RD;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD_RD:   state_d = S_ADD_WR;
			S_ADD_WR:   state_d = S_IDLE;
			S_SUM_RD:   state_d = S_SUM_MUL;
			S_SUM_MUL:  state_d = S_SUM_ACC;
			S_SUM_ACC:  state_d = sts.t_last ? S_SUM_CHK : S_SUM_RD;
			S_SUM_CHK:  state_d = sts.all_zero ? S_RES : S_SCAN_RD;
			S_SCAN_RD:  state_d = S_SCAN_MUL;
			S_SCAN_MUL: state_d = S_SCAN_ACC;
			S_SCAN_ACC: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (sts.side_zero) begin
					state_d = S_NEXT;
				end else begin
					state_d = S_MUL_GO;
					sel_d   = M_P;
				end
			end
			S_MUL_GO:   state_d = S_MUL_WAIT;
			S_MUL_WAIT: begin
				if (!sts.mul_busy) begin
					unique case (sel_q)
						M_P:     begin sel_d = M_Q;   state_d = S_MUL_GO; end
						M_Q:     begin sel_d = M_NUM; state_d = S_MUL_GO; end
						M_NUM:   begin sel_d = M_DEN; state_d = S_MUL_GO; end
						M_DEN:   begin sel_d = M_X;   state_d = S_MUL_GO; end
						M_X:     begin sel_d = M_Y;   state_d = S_MUL_GO; end
						default: state_d = S_CMP;
					endcase
				end
			end
			S_CMP:      state_d = S_NEXT;
			S_NEXT:     state_d = sts.t_last ? S_RES : S_SCAN_RD;
			S_RES:      if (sts.res_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd         = '0;
		cmd.ra_sel  = RA_T;
		cmd.mul_sel = sel_q;
		in_stall    = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				cmd.t_inc  = 1'b1;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.cap    = 1'b1;
					cmd.t_zero = 1'b1;
				end
			end
			S_ADD_RD:   cmd.ra_sel = RA_BIN;
			S_ADD_WR:   cmd.add_we = 1'b1;
			S_SUM_RD:   cmd.ra_sel = RA_T;
			S_SUM_MUL:  cmd.prod_ld = 1'b1;
			S_SUM_ACC: begin
				cmd.sum_acc = 1'b1;
				cmd.t_inc   = !sts.t_last;
			end
			S_SUM_CHK: begin
				cmd.scan_init = 1'b1;
				cmd.t_one     = 1'b1;
			end
			S_SCAN_RD:  cmd.ra_sel = RA_TM1;
			S_SCAN_MUL: cmd.prod_ld = 1'b1;
			S_SCAN_ACC: cmd.scan_acc = 1'b1;
			S_SCAN_CHK: ;
			S_MUL_GO:   cmd.mul_go = 1'b1;
			S_MUL_WAIT: cmd.mul_store = !sts.mul_busy;
			S_CMP:      cmd.cmp = 1'b1;
			S_NEXT:     cmd.t_inc = !sts.t_last;
			S_RES:      cmd.res_load = sts.res_free;
			default:    ;
		endcase
	end

endmodule

/* design/histogram_min_variance_threshold.sv */
// An add reads the bin and writes it back; a clear walks every bin; a threshold runs a
// totals pass over all bins and then, per split with both classes nonempty, 6 shared
// shift-add products, each running until its multiplier has no set bits left.
// Throughput: one item at a time; the shared multiplier sets the threshold time.
// Reset: asynchronous, active low; then a clearing pass zeroes the bins, during which
// no item is taken.
module histogram_min_variance_threshold #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hmvt_pkg::OPCODE_W-1:0] opcode,
	input  logic [hmvt_pkg::BIN_W-1:0]    bin_index,
	input  logic [hmvt_pkg::ADD_W-1:0]    add_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hmvt_pkg::THR_W-1:0]    threshold_bin,
	output logic                          histogram_empty
);
	import hmvt_pkg::*;

	// Commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	// Sequencer: decode each transfer, walk the bins, step the product chain
	hmvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode  (opcode),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath: bin memory, class sums, shared multiplier, best split, result register
	hmvt_dp #(
		.BINS      (BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.bin_index      (bin_index),
		.add_count      (add_count),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.threshold_bin  (threshold_bin),
		.histogram_empty(histogram_empty)
	);

endmodule

/* design/hmvt_chk.sv */
module hmvt_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [hmvt_pkg::THR_W-1:0] threshold_bin,
	input logic                       histogram_empty
);
	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(threshold_bin) && $stable(histogram_empty))
		else $error("result changed while stalled");

	// An empty histogram always reports bin zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && histogram_empty |-> threshold_bin == '0)
		else $error("empty histogram with nonzero threshold");

	// A result never appears right after an input transfer
	a_no_quick_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result raised right after input transfer");

endmodule

bind histogram_min_variance_threshold hmvt_chk u_chk (.*);
